FILE: src/clcd4_pkg.sv
// Shared types, codes and constants for the 4-bit character LCD command sequencer.
`timescale 1ns / 1ps
package clcd4_pkg;

    // Display geometry: columns per text line (1 to 32).
    localparam int LINE_WIDTH = 16;
    // Most spaces one line-end transaction pads before handing back control.
    localparam int MAX_SPACES = 16;

    localparam logic [5:0] LINE_WIDTH_C = 6'(LINE_WIDTH);
    localparam logic [5:0] MAX_SPACES_C = 6'(MAX_SPACES);

    // Input command codes
    localparam logic [2:0] CMD_INIT       = 3'd0;
    localparam logic [2:0] CMD_CLEAR      = 3'd1;
    localparam logic [2:0] CMD_LINE_START = 3'd2;
    localparam logic [2:0] CMD_CHAR       = 3'd3;
    localparam logic [2:0] CMD_LINE_END   = 3'd4;

    // LCD command bytes and nibbles
    localparam logic [7:0] LCD_FUNC_SET   = 8'h28;
    localparam logic [7:0] LCD_DISP_ON    = 8'h0C;
    localparam logic [7:0] LCD_ENTRY_MODE = 8'h06;
    localparam logic [7:0] LCD_CLEAR      = 8'h01;
    localparam logic [7:0] LCD_SET_DDRAM  = 8'h80;
    localparam logic [7:0] LCD_ROW1_OFS   = 8'h40;
    localparam logic [7:0] LCD_SPACE      = 8'h20;
    localparam logic [3:0] NIB_WAKE       = 4'h3;
    localparam logic [3:0] NIB_4BIT       = 4'h2;

    // Strobe counts
    localparam logic [5:0] INIT_STROBES   = 6'd12;
    localparam logic [5:0] BYTE_STROBES   = 6'd2;
    localparam logic [4:0] INIT_WAKE_LAST = 5'd3;
    localparam logic [4:0] INIT_LAST_STEP = 5'd11;

    // Waits in microseconds
    localparam logic [15:0] PRE_POWER_ON  = 16'd50000;
    localparam logic [12:0] POST_BASE     = 13'd50;
    localparam logic [12:0] POST_WAKE     = 13'd250;
    localparam logic [12:0] POST_FIRST    = 13'd5050;
    localparam logic [12:0] POST_CLEAR    = 13'd2050;

    // Init command bytes after the wake-up nibbles
    function automatic logic [7:0] init_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = LCD_FUNC_SET;
            2'd1:    b = LCD_DISP_ON;
            2'd2:    b = LCD_ENTRY_MODE;
            default: b = LCD_CLEAR;
        endcase
        return b;
    endfunction

    typedef struct packed {
        logic [2:0] cmd;
        logic       row;
        logic [7:0] char_code;
    } item_t;

    typedef struct packed {
        logic        reg_select;
        logic [3:0]  nibble;
        logic [15:0] pre_wait_us;
        logic [12:0] post_wait_us;
        logic        last;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_SEND
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_item;
        logic load_strobe;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic none;
        logic last;
    } dp_stat_t;

endpackage

FILE: src/clcd4_ctrl.sv
// Control state machine for the LCD command sequencer.
`timescale 1ns / 1ps
module clcd4_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    output logic                result_valid,
    input  logic                result_ready,
    output clcd4_pkg::dp_cmd_t  dp_cmd,
    input  clcd4_pkg::dp_stat_t dp_stat
);
    import clcd4_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next          = state_reg;
        item_ready          = 1'b0;
        result_valid        = 1'b0;
        dp_cmd.load_item    = 1'b0;
        dp_cmd.load_strobe  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    dp_cmd.load_item = 1'b1;
                    state_next       = ST_START;
                end
            end
            ST_START:
            begin
                if (dp_stat.none)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    dp_cmd.load_strobe = 1'b1;
                    state_next         = ST_SEND;
                end
            end
            ST_SEND:
            begin
                result_valid = 1'b1;
                if (result_ready)
                begin
                    if (dp_stat.last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        dp_cmd.load_strobe = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: src/clcd4_dp.sv
// Datapath: line state, strobe counter and strobe field generation.
`timescale 1ns / 1ps
module clcd4_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  clcd4_pkg::item_t     item,
    input  clcd4_pkg::dp_cmd_t   dp_cmd,
    output clcd4_pkg::dp_stat_t  dp_stat,
    output clcd4_pkg::result_t   result
);
    import clcd4_pkg::*;

    logic [5:0]  col_reg, col_next;
    logic        open_reg, open_next;
    logic [5:0]  count_reg, count_next;
    logic [4:0]  step_reg;
    logic [2:0]  cmd_reg;
    logic        row_reg;
    logic [7:0]  char_reg;
    result_t     out_reg;

    logic [5:0]  room;
    logic [5:0]  spaces;
    logic [5:0]  col_pad;
    logic        strobe_last;
    result_t     strobe;
    logic [7:0]  sel_byte;
    logic [4:0]  init_ofs;

    // Work out strobe count and new line state for an incoming transaction
    always_comb
    begin
        room       = LINE_WIDTH_C - col_reg;
        spaces     = (room > MAX_SPACES_C) ? MAX_SPACES_C : room;
        col_pad    = col_reg + spaces;
        col_next   = col_reg;
        open_next  = open_reg;
        count_next = 6'd0;
        case (item.cmd)
            CMD_INIT:
            begin
                count_next = INIT_STROBES;
                col_next   = 6'd0;
                open_next  = 1'b0;
            end
            CMD_CLEAR:
            begin
                count_next = BYTE_STROBES;
                col_next   = 6'd0;
                open_next  = 1'b0;
            end
            CMD_LINE_START:
            begin
                count_next = BYTE_STROBES;
                col_next   = 6'd0;
                open_next  = 1'b1;
            end
            CMD_CHAR, CMD_LINE_END:
            begin
                if (item.cmd == CMD_LINE_END || item.char_code == 8'd0)
                begin
                    if (open_reg)
                    begin
                        if (col_reg < LINE_WIDTH_C)
                        begin
                            count_next = {spaces[4:0], 1'b0};
                            col_next   = col_pad;
                            open_next  = (col_pad < LINE_WIDTH_C);
                        end
                        else
                        begin
                            open_next = 1'b0;
                        end
                    end
                end
                else if (open_reg && col_reg < LINE_WIDTH_C)
                begin
                    count_next = BYTE_STROBES;
                    col_next   = col_reg + 6'd1;
                end
            end
            default:
            begin
                count_next = 6'd0;
            end
        endcase
    end

    // Fields of the strobe selected by step_reg
    always_comb
    begin
        init_ofs            = step_reg - 5'd4;
        sel_byte            = LCD_SPACE;
        strobe.reg_select   = 1'b0;
        strobe.nibble       = 4'd0;
        strobe.pre_wait_us  = 16'd0;
        strobe.post_wait_us = POST_BASE;
        strobe_last         = ({1'b0, step_reg} == (count_reg - 6'd1));
        strobe.last         = strobe_last;
        case (cmd_reg)
            CMD_INIT:     sel_byte = init_byte(init_ofs[2:1]);
            CMD_CLEAR:    sel_byte = LCD_CLEAR;
            CMD_LINE_START:
                sel_byte = LCD_SET_DDRAM | (row_reg ? LCD_ROW1_OFS : 8'h00);
            CMD_CHAR:     sel_byte = (char_reg == 8'd0) ? LCD_SPACE : char_reg;
            default:      sel_byte = LCD_SPACE;
        endcase
        strobe.reg_select = (cmd_reg == CMD_CHAR) || (cmd_reg == CMD_LINE_END);
        strobe.nibble     = step_reg[0] ? sel_byte[3:0] : sel_byte[7:4];
        if (cmd_reg == CMD_INIT)
        begin
            if (step_reg <= INIT_WAKE_LAST)
            begin
                strobe.nibble       = (step_reg == INIT_WAKE_LAST) ? NIB_4BIT : NIB_WAKE;
                strobe.pre_wait_us  = (step_reg == 5'd0) ? PRE_POWER_ON : 16'd0;
                strobe.post_wait_us = (step_reg == 5'd0) ? POST_FIRST : POST_WAKE;
            end
            else if (step_reg == INIT_LAST_STEP)
            begin
                strobe.post_wait_us = POST_CLEAR;
            end
        end
        else if (cmd_reg == CMD_CLEAR && step_reg[0])
        begin
            strobe.post_wait_us = POST_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= 6'd0;
            open_reg  <= 1'b0;
            count_reg <= 6'd0;
            step_reg  <= 5'd0;
        end
        else if (dp_cmd.load_item)
        begin
            col_reg   <= col_next;
            open_reg  <= open_next;
            count_reg <= count_next;
            step_reg  <= 5'd0;
        end
        else if (dp_cmd.load_strobe)
        begin
            step_reg <= step_reg + 5'd1;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (dp_cmd.load_item)
        begin
            cmd_reg  <= item.cmd;
            row_reg  <= item.row;
            char_reg <= item.char_code;
        end
        if (dp_cmd.load_strobe)
        begin
            out_reg <= strobe;
        end
    end

    assign dp_stat.none = (count_reg == 6'd0);
    assign dp_stat.last = out_reg.last;
    assign result       = out_reg;

endmodule

FILE: src/char_lcd_4bit_command_sequencer.sv
// Top level of the 4-bit character LCD command sequencer.
`timescale 1ns / 1ps
// Turns high-level display requests (init, clear, line start, character,
// line end) into the enable strobes of an HD44780-style panel on a 4-bit
// bus. Each result transaction is one strobe: RS level, the nibble for
// D7..D4, the wait before the strobe and the wait after enable falls; the
// last strobe of a request carries last=1. Sequencing: a request is taken
// in the idle state, the next cycle sets up the first strobe, and after
// that one strobe is offered per cycle for as long as the consumer takes
// them. A request gives N strobes (init 12, clear, line start and a
// character 2, a padding line end up to 32); the strobe counter in the
// datapath, stepping one strobe per output transaction, sets N. A request
// that produces no strobes (character past the line width or outside a
// line, a line end with no line to pad, unused command codes) completes
// with no output. One request is in flight at a time; item_ready is low
// from acceptance until its last strobe is taken.
module char_lcd_4bit_command_sequencer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  clcd4_pkg::item_t    item,
    output logic                result_valid,
    input  logic                result_ready,
    output clcd4_pkg::result_t  result
);
    import clcd4_pkg::*;

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    // Sequencing: idle / set up first strobe / offer strobes
    clcd4_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .dp_cmd       (dp_cmd),
        .dp_stat      (dp_stat)
    );

    // Line state, strobe counter and output register
    clcd4_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .dp_cmd  (dp_cmd),
        .dp_stat (dp_stat),
        .result  (result)
    );

endmodule

FILE: src/clcd4_chk.sv
// Port-level assertions for the LCD command sequencer, bound to the top level.
`timescale 1ns / 1ps
module clcd4_chk (
    input logic               clk,
    input logic               rst_n,
    input logic               item_ready,
    input logic               result_valid,
    input logic               result_ready,
    input clcd4_pkg::result_t result
);
    import clcd4_pkg::*;

    // A stalled result transaction holds its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result))
        else $error("result changed while stalled");

    // New requests are not taken while strobes are still being offered
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(item_ready && result_valid))
        else $error("item_ready while result pending");

    // After the last strobe of a request the output goes quiet
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && result.last |=> !result_valid)
        else $error("result valid after last strobe");

    // Data strobes never carry setup waits
    a_data: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.reg_select |->
            result.pre_wait_us == 16'd0 && result.post_wait_us == POST_BASE)
        else $error("data strobe with unexpected waits");

    // Only the power-on wake nibble waits before its strobe
    a_pre: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.pre_wait_us != 16'd0 |->
            result.nibble == NIB_WAKE && !result.reg_select
            && result.post_wait_us == POST_FIRST)
        else $error("pre-wait on wrong strobe");

endmodule

bind char_lcd_4bit_command_sequencer clcd4_chk u_clcd4_chk (.*);

FILE: tb/sv/char_lcd_4bit_command_sequencer_test.sv
// Self-checking testbench for the 4-bit character LCD command sequencer.
`timescale 1ns / 1ps
module char_lcd_4bit_command_sequencer_test;
    import clcd4_pkg::*;

    // Command codes 5..7 are spare; the block must take them and do nothing.
    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

    // A cycle with no transaction on either channel counts toward this limit.
    // The slowest correct gap is a sender wait plus request setup plus a
    // receiver stall, so this leaves a wide margin.
    localparam int IDLE_LIMIT   = 2000;
    // Random stimulus size (counted items only, spare codes excluded).
    localparam int RANDOM_ITEMS = 200;
    // Request setup plus the longest strobe burst, rounded up.
    localparam int TAIL_CYCLES  = 40;

    // ------------------------------------------------------------------
    // Strobe predictor and scoreboard. Keeps its own copy of the column
    // count and line-open flag, expands each accepted request into the
    // nibble strobes it must produce, and compares strobes in order.
    // ------------------------------------------------------------------
    class lcd_strobe_scoreboard;
        result_t     pending[$];
        logic [5:0]  col_count;
        logic        row_open;
        int          errors;

        function new();
            col_count = '0;
            row_open  = 1'b0;
            errors    = 0;
        endfunction

        task report(string msg);
            $display("%0t ns: mismatch: %s", $time, msg);
            errors++;
        endtask

        function void add_strobe(logic rs, logic [3:0] nib, logic [15:0] pre,
                                 logic [12:0] post);
            result_t r;
            r.reg_select   = rs;
            r.nibble       = nib;
            r.pre_wait_us  = pre;
            r.post_wait_us = post;
            r.last         = 1'b0;
            pending.push_back(r);
        endfunction

        // High nibble first; only the low nibble carries the long settle time.
        function void add_octet(logic rs, logic [7:0] octet, logic [12:0] post_low);
            add_strobe(rs, octet[7:4], 16'd0, POST_BASE);
            add_strobe(rs, octet[3:0], 16'd0, post_low);
        endfunction

        // Space padding: bounded per request, line closes once full.
        function void pad_row();
            logic [5:0] sent;
            sent = '0;
            if (!row_open)
                return;
            while (col_count < LINE_WIDTH_C && sent < MAX_SPACES_C) begin
                add_octet(1'b1, LCD_SPACE, POST_BASE);
                col_count++;
                sent++;
            end
            if (col_count >= LINE_WIDTH_C)
                row_open = 1'b0;
        endfunction

        function void note_item(item_t it);
            int first;
            first = pending.size();
            case (it.cmd)
                CMD_INIT:
                begin
                    add_strobe(1'b0, NIB_WAKE, PRE_POWER_ON, POST_FIRST);
                    add_strobe(1'b0, NIB_WAKE, 16'd0, POST_WAKE);
                    add_strobe(1'b0, NIB_WAKE, 16'd0, POST_WAKE);
                    add_strobe(1'b0, NIB_4BIT, 16'd0, POST_WAKE);
                    add_octet(1'b0, LCD_FUNC_SET, POST_BASE);
                    add_octet(1'b0, LCD_DISP_ON, POST_BASE);
                    add_octet(1'b0, LCD_ENTRY_MODE, POST_BASE);
                    add_octet(1'b0, LCD_CLEAR, POST_CLEAR);
                    col_count = '0;
                    row_open  = 1'b0;
                end
                CMD_CLEAR:
                begin
                    add_octet(1'b0, LCD_CLEAR, POST_CLEAR);
                    col_count = '0;
                    row_open  = 1'b0;
                end
                CMD_LINE_START:
                begin
                    add_octet(1'b0, LCD_SET_DDRAM | (it.row ? LCD_ROW1_OFS : 8'h00),
                              POST_BASE);
                    col_count = '0;
                    row_open  = 1'b1;
                end
                CMD_CHAR:
                begin
                    if (it.char_code == 8'h00)
                        pad_row();
                    else if (row_open && col_count < LINE_WIDTH_C)
                    begin
                        add_octet(1'b1, it.char_code, POST_BASE);
                        col_count++;
                    end
                end
                CMD_LINE_END:
                    pad_row();
                default:
                    ;
            endcase
            if (pending.size() > first)
                pending[pending.size() - 1].last = 1'b1;
        endfunction

        task check_result(result_t got);
            result_t want;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected strobe rs=%0d nib=%h pre=%0d post=%0d last=%0d",
                                 got.reg_select, got.nibble, got.pre_wait_us,
                                 got.post_wait_us, got.last));
                return;
            end
            want = pending.pop_front();
            if (got.reg_select !== want.reg_select)
                report($sformatf("reg_select %0d, want %0d", got.reg_select,
                                 want.reg_select));
            if (got.nibble !== want.nibble)
                report($sformatf("nibble %h, want %h", got.nibble, want.nibble));
            if (got.pre_wait_us !== want.pre_wait_us)
                report($sformatf("pre_wait_us %0d, want %0d", got.pre_wait_us,
                                 want.pre_wait_us));
            if (got.post_wait_us !== want.post_wait_us)
                report($sformatf("post_wait_us %0d, want %0d", got.post_wait_us,
                                 want.post_wait_us));
            if (got.last !== want.last)
                report($sformatf("last %0d, want %0d", got.last, want.last));
        endtask
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and block hookup. All inputs start at known values.
    // ------------------------------------------------------------------
    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_ready;
    item_t   item         = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;

    // Idle-free stretches: when set, that side never waits between items.
    bit      tx_steady    = 1'b0;
    bit      rx_steady    = 1'b0;
    int      counted_items;
    int      idle_cycles;

    lcd_strobe_scoreboard sb;

    always #2 clk = ~clk;

    char_lcd_4bit_command_sequencer uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // Watchdog: a hung handshake on either side ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL char_lcd_4bit_command_sequencer");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic int draw_wait(bit steady);
        return steady ? 0 : $urandom_range(0, 11);
    endfunction

    function automatic item_t mk_item(logic [2:0] c, logic r, logic [7:0] ch);
        item_t it;
        it.cmd       = c;
        it.row       = r;
        it.char_code = ch;
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Request driver. Valid is left high on return so back-to-back
    // transactions never lower and raise it in the same time step; the
    // next call lowers it only if it draws a gap.
    // ------------------------------------------------------------------
    task send_item(input item_t it);
        int gap;
        gap = draw_wait(tx_steady);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready) @(posedge clk);
        sb.note_item(it);
        if (it.cmd <= CMD_LINE_END)
            counted_items++;
        if ($urandom_range(0, 24) == 0)
            tx_steady = !tx_steady;
    endtask

    // Hold off the sender until every predicted strobe has been taken.
    // Always waits on the clock before checking, so valid is not toggled twice.
    task drain_results();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    // Well-formed text line with random content: line start, some
    // characters (sometimes past the line width), then one or two terminators or none.
    task text_line();
        int n;
        int term;
        send_item(mk_item(CMD_LINE_START, 1'($urandom_range(0, 1)), 8'($urandom)));
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 15);
        repeat (n)
            send_item(mk_item(CMD_CHAR, 1'($urandom_range(0, 1)),
                              8'($urandom_range(1, 255))));
        term = $urandom_range(0, 9);
        if (term <= 4)
            send_item(mk_item(CMD_LINE_END, 1'($urandom_range(0, 1)), 8'($urandom)));
        else if (term <= 7)
            send_item(mk_item(CMD_CHAR, 1'($urandom_range(0, 1)), 8'h00));
        else if (term == 9)
        begin
            // Second terminator must find the line already closed.
            send_item(mk_item(CMD_LINE_END, 1'($urandom_range(0, 1)), 8'($urandom)));
            send_item(mk_item(CMD_CHAR, 1'($urandom_range(0, 1)), 8'h00));
        end
        // term == 8: line left open; a later request deals with it
    endtask

    // Noise: any code, any fields, including the spare codes.
    task noise_item();
        send_item(mk_item(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                          8'($urandom)));
    endtask

    // ------------------------------------------------------------------
    // Strobe receiver: random stalls, idle-free stretches now and then.
    // ------------------------------------------------------------------
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = draw_wait(rx_steady);
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            @(posedge clk);
            while (!result_valid) @(posedge clk);
            sb.check_result(result);
            if ($urandom_range(0, 29) == 0)
                rx_steady = !rx_steady;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence: reset, directed cases, random lines and noise, drain.
    // ------------------------------------------------------------------
    initial
    begin
        logic [2:0] spare;
        sb = new();
        counted_items = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: power-on init and clear first.
        send_item(mk_item(CMD_INIT, 1'b0, 8'h00));
        send_item(mk_item(CMD_CLEAR, 1'b1, 8'hFF));
        // Top row, extreme character codes, then padded by line end.
        send_item(mk_item(CMD_LINE_START, 1'b0, 8'h00));
        send_item(mk_item(CMD_CHAR, 1'b0, 8'h01));
        send_item(mk_item(CMD_CHAR, 1'b1, 8'hFF));
        send_item(mk_item(CMD_CHAR, 1'b0, 8'h80));
        send_item(mk_item(CMD_LINE_END, 1'b0, 8'h00));
        // No line open: character, line end and zero byte all drop.
        send_item(mk_item(CMD_CHAR, 1'b0, 8'h41));
        send_item(mk_item(CMD_LINE_END, 1'b1, 8'hFF));
        send_item(mk_item(CMD_CHAR, 1'b1, 8'h00));
        // Bottom row ended by a zero byte.
        send_item(mk_item(CMD_LINE_START, 1'b1, 8'hFF));
        send_item(mk_item(CMD_CHAR, 1'b0, 8'h55));
        send_item(mk_item(CMD_CHAR, 1'b1, 8'hAA));
        send_item(mk_item(CMD_CHAR, 1'b0, 8'h00));
        // Line start while a line is open drops the old line unpadded.
        send_item(mk_item(CMD_LINE_START, 1'b0, 8'h7F));
        send_item(mk_item(CMD_CHAR, 1'b0, 8'h7E));
        send_item(mk_item(CMD_LINE_START, 1'b1, 8'h00));
        send_item(mk_item(CMD_LINE_END, 1'b0, 8'h00));
        // Spare codes with both field extremes.
        for (spare = CMD_SPARE_FIRST; ; spare++)
        begin
            send_item(mk_item(spare, 1'b1, 8'hFF));
            send_item(mk_item(spare, 1'b0, 8'h00));
            if (spare == CMD_SPARE_LAST)
                break;
        end
        // Clear from an open line, then init.
        send_item(mk_item(CMD_LINE_START, 1'b0, 8'h00));
        send_item(mk_item(CMD_CLEAR, 1'b0, 8'h00));
        send_item(mk_item(CMD_INIT, 1'b1, 8'hFF));

        // Sender holds off until the display side has caught up.
        drain_results();

        counted_items = 0;
        while (counted_items < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 3) != 0)
                text_line();
            else
                noise_item();
            if (counted_items >= RANDOM_ITEMS / 2 && counted_items < RANDOM_ITEMS / 2 + 20
                && $urandom_range(0, 1) == 0)
                drain_results();
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASS char_lcd_4bit_command_sequencer");
        else
        begin
            if (sb.pending.size() != 0)
                $display("%0d strobes never arrived", sb.pending.size());
            $display("FAIL char_lcd_4bit_command_sequencer");
        end
        $finish;
    end

endmodule

FILE: sim.f
src/clcd4_pkg.sv
src/clcd4_ctrl.sv
src/clcd4_dp.sv
src/char_lcd_4bit_command_sequencer.sv
src/clcd4_chk.sv
tb/sv/char_lcd_4bit_command_sequencer_test.sv
